/* design/bdam_pkg.sv */
// Package for the BCD date/time minute adder.
// Holds calendar constants, the month length table and BCD helper functions.
// No dependencies.
`timescale 1ns / 1ps

package bdam_pkg;

    localparam int C_FIELD_W = 8;
    localparam int C_ADD_W   = 16;
    localparam int C_IN_W    = 56;
    localparam int C_OUT_W   = 40;
    localparam int C_QUOT_W  = 5;
    localparam int C_BIT_W   = 3;

    localparam logic [C_ADD_W-1:0]   C_MIN_PER_DAY  = 16'd1440;
    localparam logic [C_ADD_W-1:0]   C_MIN_PER_HOUR = 16'd60;
    localparam logic [C_ADD_W-1:0]   C_HOUR_PER_DAY = 16'd24;
    localparam logic [C_BIT_W-1:0]   C_QUOT_TOP     = 3'd4;
    localparam logic [C_FIELD_W-1:0] C_MONTH_MAX    = 8'h12;
    localparam logic [C_FIELD_W-1:0] C_YEAR_MAX     = 8'h99;
    localparam logic [C_FIELD_W-1:0] C_FEBRUARY     = 8'h02;
    localparam logic [4:0]           C_LEAP_FEB_LEN = 5'd29;
    localparam logic [4:0]           C_DEFAULT_LEN  = 5'd31;

    localparam logic [4:0] C_MONTH_LEN [0:12] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [C_FIELD_W-1:0] day;
        logic [C_FIELD_W-1:0] mon;
        logic [C_FIELD_W-1:0] yr;
    } t_date;

    function automatic logic [C_FIELD_W-1:0] bcd_to_bin(input logic [C_FIELD_W-1:0] b);
        bcd_to_bin = 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
    endfunction

    // divide by ten through a reciprocal, exact for any 8-bit value
    function automatic logic [C_FIELD_W-1:0] bin_to_bcd(input logic [C_FIELD_W-1:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  lo;
        prod = 16'(v) * 16'd205;
        q    = prod[15:11];
        lo   = v - 8'(q) * 8'd10;
        bin_to_bcd = {q[3:0], lo[3:0]};
    endfunction

    function automatic logic [C_FIELD_W-1:0] bcd_inc(input logic [C_FIELD_W-1:0] b);
        logic [4:0] lo;
        logic [3:0] hi;
        lo = 5'(b[3:0]) + 5'd1;
        hi = b[7:4];
        if (lo > 5'd9) begin
            lo = 5'd0;
            hi = hi + 4'd1;
        end
        bcd_inc = {hi, lo[3:0]};
    endfunction

    function automatic t_date advance_day(input t_date d);
        logic [C_FIELD_W-1:0] m;
        logic [C_FIELD_W-1:0] y;
        logic [4:0]           limit;
        t_date                r;
        m = bcd_to_bin(d.mon);
        y = bcd_to_bin(d.yr);
        r = d;
        if (d.mon == C_FEBRUARY && y[1:0] == 2'd0) begin
            limit = C_LEAP_FEB_LEN;
        end else if (m >= 8'd1 && m <= 8'd12) begin
            limit = C_MONTH_LEN[m[3:0]];
        end else begin
            limit = C_DEFAULT_LEN;
        end
        r.day = bcd_inc(d.day);
        if (bcd_to_bin(r.day) > 8'(limit)) begin
            r.day = 8'h01;
            r.mon = bcd_inc(d.mon);
            if (r.mon > C_MONTH_MAX) begin
                r.mon = 8'h01;
                r.yr  = bcd_inc(d.yr);
                if (r.yr > C_YEAR_MAX) begin
                    r.yr = 8'h00;
                end
            end
        end
        advance_day = r;
    endfunction

endpackage

/* design/bcd_datetime_add_minutes.sv */
// Top level of the BCD date/time minute adder: sequencer around one shared
// compare-and-subtract unit. Depends on bdam_pkg.
//
// channel  dir  fields (lowest bit up)
// s_axis   in   minute_bcd, hour_bcd, day_bcd, month_bcd, year_bcd, add_minutes
// m_axis   out  new_minute_bcd, new_hour_bcd, new_day_bcd, new_month_bcd, new_year_bcd
//
// A request runs through a day loop that subtracts 1440 once per cycle, then a
// restoring division of the rest by 60 over five quotient bits, an hour step
// and a minute step, plus an hour carry step when the minute sum carries an
// hour. A zero minute count goes straight to the result.
// The input is ready only when idle, from the cycle after the result loads.
// The result sits in an output register, so a stalled output does not block
// the next request until its result is ready. Reset is synchronous, active low.
`timescale 1ns / 1ps

module bcd_datetime_add_minutes
    import bdam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // minute_bcd, hour_bcd, day_bcd, month_bcd, year_bcd, add_minutes
    input  logic [C_IN_W-1:0]  i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // new_minute_bcd, new_hour_bcd, new_day_bcd, new_month_bcd, new_year_bcd
    output logic [C_OUT_W-1:0] o_m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_DIV,
        S_HOUR,
        S_MIN,
        S_HCAR,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [C_FIELD_W-1:0]  r_mi, n_mi;
    logic [C_FIELD_W-1:0]  r_hr, n_hr;
    t_date                 r_date, n_date;
    logic [C_ADD_W-1:0]    r_rest, n_rest;
    logic [C_QUOT_W-1:0]   r_quot, n_quot;
    logic [C_BIT_W-1:0]    r_bit, n_bit;
    logic                  r_out_valid, n_out_valid;
    logic [C_OUT_W-1:0]    r_out, n_out;

    logic [C_ADD_W-1:0]    op_a, op_b;
    logic [C_ADD_W:0]      diff;
    logic                  ge;
    logic [C_FIELD_W-1:0]  sel_t;
    t_date                 adv;

    // shared compare-and-subtract unit
    always_comb begin
        case (r_state)
            S_DAY: begin
                op_a = r_rest;
                op_b = C_MIN_PER_DAY;
            end
            S_DIV: begin
                op_a = r_rest;
                op_b = C_MIN_PER_HOUR << r_bit;
            end
            S_HOUR: begin
                op_a = 16'(bcd_to_bin(r_hr) + 8'(r_quot));
                op_b = C_HOUR_PER_DAY;
            end
            S_MIN: begin
                op_a = 16'(bcd_to_bin(r_mi) + r_rest[7:0]);
                op_b = C_MIN_PER_HOUR;
            end
            S_HCAR: begin
                op_a = 16'(bcd_to_bin(r_hr) + 8'd1);
                op_b = C_HOUR_PER_DAY;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        diff  = {1'b0, op_a} - {1'b0, op_b};
        ge    = ~diff[C_ADD_W];
        sel_t = ge ? diff[7:0] : op_a[7:0];
        adv   = advance_day(r_date);
    end

    always_comb begin
        n_state     = r_state;
        n_mi        = r_mi;
        n_hr        = r_hr;
        n_date      = r_date;
        n_rest      = r_rest;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mi       = i_s_axis_tdata[7:0];
                    n_hr       = i_s_axis_tdata[15:8];
                    n_date.day = i_s_axis_tdata[23:16];
                    n_date.mon = i_s_axis_tdata[31:24];
                    n_date.yr  = i_s_axis_tdata[39:32];
                    n_rest     = i_s_axis_tdata[55:40];
                    n_quot     = '0;
                    n_bit      = C_QUOT_TOP;
                    // zero minutes: hand back the input unchanged
                    n_state    = (i_s_axis_tdata[55:40] == '0) ? S_DONE : S_DAY;
                end
            end
            S_DAY: begin
                if (ge) begin
                    n_rest = diff[C_ADD_W-1:0];
                    n_date = adv;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (ge) begin
                    n_rest        = diff[C_ADD_W-1:0];
                    n_quot[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = S_HOUR;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_HOUR: begin
                if (r_quot != '0) begin
                    n_hr = bin_to_bcd(sel_t);
                    if (ge) begin
                        n_date = adv;
                    end
                end
                n_state = S_MIN;
            end
            S_MIN: begin
                n_mi    = bin_to_bcd(sel_t);
                n_state = ge ? S_HCAR : S_DONE;
            end
            S_HCAR: begin
                n_hr    = bin_to_bcd(sel_t);
                if (ge) begin
                    n_date = adv;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = {r_date.yr, r_date.mon, r_date.day, r_hr, r_mi};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mi   <= n_mi;
        r_hr   <= n_hr;
        r_date <= n_date;
        r_rest <= n_rest;
        r_quot <= n_quot;
        r_bit  <= n_bit;
        r_out  <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule
